/* hw/rtl/qrsd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// qrsd_pkg
// Shared types and constants of the quadratic root solver.
// -----------------------------------------------------------------------------
package qrsd_pkg;

   // Width of the large-value register.
   localparam int LARGE_W = 31;
   localparam logic [LARGE_W-1:0] LARGE_RESET = {LARGE_W{1'b1}};

   // Kind of an item as it moves through the pipeline. The front only knows
   // whether the equation is quadratic; the discriminant stage refines it.
   localparam int KIND_W = 3;
   typedef enum logic [KIND_W-1:0] {
      KIND_NONE = 3'd0,
      KIND_LIN  = 3'd1,
      KIND_QUAD = 3'd2,
      KIND_ONE  = 3'd3,
      KIND_TWO  = 3'd4
   } kind_type;

   // Root counts reported on the result channel.
   localparam logic [1:0] COUNT_NONE = 2'd0;
   localparam logic [1:0] COUNT_ONE  = 2'd1;
   localparam logic [1:0] COUNT_TWO  = 2'd2;

endpackage
`default_nettype wire

/* hw/rtl/qrsd_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// qrsd_front
// Input register: takes an item, splits each coefficient into sign and
// magnitude and classifies the equation as none, linear or quadratic.
// -----------------------------------------------------------------------------
module qrsd_front import qrsd_pkg::*; #(
   parameter int COEF_WIDTH = 32
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    in_valid,
   output logic                                   in_ready,
   input  wire  [COEF_WIDTH-1:0]                  in_a,
   input  wire  [COEF_WIDTH-1:0]                  in_b,
   input  wire  [COEF_WIDTH-1:0]                  in_c,
   input  wire                                    out_ready,
   output logic                                   out_valid,
   output logic [KIND_W+3+3*COEF_WIDTH-1:0]       out_entry
);

   localparam int CW = COEF_WIDTH;

   logic          valid_ff, valid_in;
   logic [CW-1:0] a_ff, b_ff, c_ff;
   logic [CW-1:0] ma, mb, mc;
   kind_type      kind;

   // The register frees up whenever the queue takes its item.
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;

   always_comb begin
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         a_ff <= in_a;
         b_ff <= in_b;
         c_ff <= in_c;
      end
   end

   // Magnitudes are exact, the most negative value included.
   always_comb begin
      ma = a_ff[CW-1] ? CW'(-a_ff) : a_ff;
      mb = b_ff[CW-1] ? CW'(-b_ff) : b_ff;
      mc = c_ff[CW-1] ? CW'(-c_ff) : c_ff;
      if (a_ff != '0) begin
         kind = KIND_QUAD;
      end else if (b_ff != '0) begin
         kind = KIND_LIN;
      end else begin
         kind = KIND_NONE;
      end
   end

   assign out_entry = {kind, a_ff[CW-1], b_ff[CW-1], c_ff[CW-1], ma, mb, mc};

endmodule
`default_nettype wire

/* hw/rtl/qrsd_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// qrsd_queue
// Short queue between the front and the arithmetic pipeline.
// -----------------------------------------------------------------------------
module qrsd_queue import qrsd_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              in_valid,
   output logic             in_ready,
   input  wire  [WIDTH-1:0] in_data,
   input  wire              out_pop,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data
);

   localparam int DEPTH = 4;
   localparam int PW    = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [PW:0]      fill_ff, fill_in;
   logic             push;

   assign in_ready  = (fill_ff != (PW+1)'(DEPTH));
   assign out_valid = (fill_ff != '0);
   assign out_data  = mem_ff[rptr_ff];
   assign push      = in_valid && in_ready;

   // Pointer and fill bookkeeping.
   always_comb begin
      wptr_in = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = out_pop ? rptr_ff + 1'b1 : rptr_ff;
      fill_in = fill_ff + (PW+1)'(push) - (PW+1)'(out_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= in_data;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/qrsd_disc.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// qrsd_disc
// Two stages: the products b*b and a*c, then the exact discriminant and the
// final root kind of a quadratic item.
// -----------------------------------------------------------------------------
module qrsd_disc import qrsd_pkg::*; #(
   parameter int COEF_WIDTH = 32
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  adv,
   input  wire                                  in_valid,
   input  wire  [KIND_W+3+3*COEF_WIDTH-1:0]     in_entry,
   output logic                                 out_valid,
   output logic [2*COEF_WIDTH+1:0]              out_rad,
   output logic [KIND_W+3+3*COEF_WIDTH-1:0]     out_tag
);

   localparam int CW = COEF_WIDTH;
   localparam int EW = KIND_W + 3 + 3*CW;
   localparam int DW = 2*CW + 2;

   logic            s1_valid_ff, s2_valid_ff;
   logic [EW-1:0]   s1_tag_ff, s2_tag_ff;
   logic [2*CW-1:0] s1_bb_ff, s1_ac_ff;
   logic            s1_add_ff;
   logic [DW-1:0]   s2_rad_ff;
   logic            add_in;
   logic [DW-1:0]   dm;
   kind_type        kind1, kind2;

   // The terms add when a and c differ in sign or c is zero.
   always_comb begin
      add_in = (in_entry[CW-1:0] == '0) || (in_entry[3*CW+2] != in_entry[3*CW]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Product stage.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_tag_ff <= in_entry;
         s1_bb_ff  <= in_entry[2*CW-1:CW] * in_entry[2*CW-1:CW];
         s1_ac_ff  <= in_entry[3*CW-1:2*CW] * in_entry[CW-1:0];
         s1_add_ff <= add_in;
      end
   end

   // Discriminant stage: zero gives one root, negative none.
   always_comb begin
      kind1 = kind_type'(s1_tag_ff[EW-1 -: KIND_W]);
      dm    = s1_add_ff ? DW'(s1_bb_ff) + {s1_ac_ff, 2'b00}
                        : DW'(s1_bb_ff) - {s1_ac_ff, 2'b00};
      kind2 = kind1;
      if (kind1 == KIND_QUAD) begin
         if (dm == '0) begin
            kind2 = KIND_ONE;
         end else if (dm[DW-1]) begin
            kind2 = KIND_NONE;
         end else begin
            kind2 = KIND_TWO;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_tag_ff <= {kind2, s1_tag_ff[EW-KIND_W-1:0]};
         s2_rad_ff <= (kind2 == KIND_TWO) ? dm : '0;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_rad   = s2_rad_ff;
   assign out_tag   = s2_tag_ff;

endmodule
`default_nettype wire

/* hw/rtl/qrsd_sqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// qrsd_sqrt
// Pipelined integer square root, one root bit per stage, with a tag carried
// alongside each radicand.
// -----------------------------------------------------------------------------
module qrsd_sqrt import qrsd_pkg::*; #(
   parameter int COEF_WIDTH = 32,
   parameter int TAG_W      = 8
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         adv,
   input  wire                         in_valid,
   input  wire  [2*COEF_WIDTH+1:0]     in_rad,
   input  wire  [TAG_W-1:0]            in_tag,
   output logic                        out_valid,
   output logic [COEF_WIDTH:0]         out_root,
   output logic [TAG_W-1:0]            out_tag
);

   localparam int SW   = COEF_WIDTH + 1;
   localparam int RADW = 2*SW;
   localparam int RMW  = SW + 2;

   logic             valid_ff [SW];
   logic [RADW-1:0]  rad_ff   [SW];
   logic [RMW-1:0]   rem_ff   [SW];
   logic [SW-1:0]    root_ff  [SW];
   logic [TAG_W-1:0] tag_ff   [SW];

   for (genvar k = 0; k < SW; k++) begin : g_stage
      logic             v_src;
      logic [RADW-1:0]  rad_src;
      logic [RMW-1:0]   rem_src;
      logic [SW-1:0]    root_src;
      logic [TAG_W-1:0] tag_src;
      logic [RMW+1:0]   rem_sh, trial;
      logic [RMW-1:0]   rem_in;
      logic [SW-1:0]    root_in;

      if (k == 0) begin : g_first
         assign v_src    = in_valid;
         assign rad_src  = in_rad;
         assign rem_src  = '0;
         assign root_src = '0;
         assign tag_src  = in_tag;
      end else begin : g_next
         assign v_src    = valid_ff[k-1];
         assign rad_src  = rad_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign tag_src  = tag_ff[k-1];
      end

      // Bring down two radicand bits and try the next root bit.
      always_comb begin
         rem_sh = {rem_src, rad_src[RADW-1 -: 2]};
         trial  = (RMW+2)'({root_src, 2'b01});
         if (rem_sh >= trial) begin
            rem_in  = RMW'(rem_sh - trial);
            root_in = {root_src[SW-2:0], 1'b1};
         end else begin
            rem_in  = RMW'(rem_sh);
            root_in = {root_src[SW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rad_ff[k]  <= rad_src << 2;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            tag_ff[k]  <= tag_src;
         end
      end
   end

   assign out_valid = valid_ff[SW-1];
   assign out_root  = root_ff[SW-1];
   assign out_tag   = tag_ff[SW-1];

endmodule
`default_nettype wire

/* hw/rtl/qrsd_solve.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// qrsd_solve
// Forms the numerators and divisor, then runs two guarded dividers in
// lockstep, one quotient bit per stage, and formats the roots.
// -----------------------------------------------------------------------------
module qrsd_solve import qrsd_pkg::*; #(
   parameter int COEF_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 adv,
   input  wire                                 in_valid,
   input  wire  [COEF_WIDTH:0]                 in_root,
   input  wire  [KIND_W+3+3*COEF_WIDTH-1:0]    in_tag,
   input  wire  [COEF_WIDTH-2:0]               lim,
   output logic                                out_valid,
   output logic [1:0]                          out_count,
   output logic [COEF_WIDTH-1:0]               out_first,
   output logic [COEF_WIDTH-1:0]               out_second
);

   localparam int CW   = COEF_WIDTH;
   localparam int EW   = KIND_W + 3 + 3*CW;
   localparam int NW   = CW + 3;
   localparam int NMW  = CW + 2;
   localparam int DMW  = CW + 1;
   localparam int NB   = NMW + FRAC_BITS;
   localparam int QB   = CW - 1;
   localparam int RW   = DMW;
   localparam int CMPW = (NB > 2*CW) ? NB : 2*CW;

   // ---- Numerator stage ----
   kind_type              kind_t;
   logic signed [NW-1:0]  nb, nc, sx;
   logic signed [NW-1:0]  nv [2];
   logic signed [NW-1:0]  nabs [2];

   logic                  a_valid_ff;
   kind_type              a_kind_ff;
   logic [1:0]            a_nneg_ff;
   logic [NMW-1:0]        a_nmag_ff [2];
   logic                  a_dneg_ff;
   logic [DMW-1:0]        a_dmag_ff;

   always_comb begin
      kind_t = kind_type'(in_tag[EW-1 -: KIND_W]);
      nb = in_tag[3*CW+1] ? $signed(NW'(in_tag[2*CW-1:CW]))
                          : -$signed(NW'(in_tag[2*CW-1:CW]));
      nc = in_tag[3*CW]   ? $signed(NW'(in_tag[CW-1:0]))
                          : -$signed(NW'(in_tag[CW-1:0]));
      sx = $signed(NW'(in_root));
      nv[0] = (kind_t == KIND_LIN) ? nc : nb - sx;
      nv[1] = nb + sx;
      nabs[0] = nv[0][NW-1] ? -nv[0] : nv[0];
      nabs[1] = nv[1][NW-1] ? -nv[1] : nv[1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_kind_ff    <= kind_t;
         a_nneg_ff    <= {nv[1][NW-1], nv[0][NW-1]};
         a_nmag_ff[0] <= nabs[0][NMW-1:0];
         a_nmag_ff[1] <= nabs[1][NMW-1:0];
         // Divisor is b for the linear case and 2a otherwise.
         if (kind_t == KIND_LIN) begin
            a_dneg_ff <= in_tag[3*CW+1];
            a_dmag_ff <= DMW'(in_tag[2*CW-1:CW]);
         end else begin
            a_dneg_ff <= in_tag[3*CW+2];
            a_dmag_ff <= {in_tag[3*CW-1:2*CW], 1'b0};
         end
      end
   end

   // ---- Divider arrays: index 0 is the set-up stage ----
   logic           valid_ff [QB+1];
   kind_type       kind_ff  [QB+1];
   logic [DMW-1:0] dmag_ff  [QB+1];
   logic [1:0]     nz_ff    [QB+1];
   logic [1:0]     ovf_ff   [QB+1];
   logic [1:0]     neg_ff   [QB+1];
   logic [1:0]     nneg_ff  [QB+1];
   logic           dz_ff    [QB+1];
   logic [RW-1:0]  rem_ff   [QB+1][2];
   logic [QB-1:0]  q_ff     [QB+1][2];
   logic [QB-1:0]  nlow_ff  [QB+1][2];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= in_valid;
      end
   end

   // Set-up: scale the numerator, test for quotient overflow and seed the
   // remainder with the bits above the quotient window.
   for (genvar l = 0; l < 2; l++) begin : g_setup
      logic [NB-1:0]   nsc;
      logic [2*CW-1:0] dsh;
      logic            ovf;

      always_comb begin
         nsc = {a_nmag_ff[l], {FRAC_BITS{1'b0}}};
         dsh = {a_dmag_ff, {(CW-1){1'b0}}};
         ovf = CMPW'(nsc) >= CMPW'(dsh);
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[0][l]  <= RW'(nsc >> (CW-1));
            q_ff[0][l]    <= '0;
            nlow_ff[0][l] <= nsc[QB-1:0];
            nz_ff[0][l]   <= (a_nmag_ff[l] == '0);
            ovf_ff[0][l]  <= ovf;
            neg_ff[0][l]  <= a_nneg_ff[l] ^ a_dneg_ff;
            nneg_ff[0][l] <= a_nneg_ff[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kind_ff[0] <= a_kind_ff;
         dmag_ff[0] <= a_dmag_ff;
         dz_ff[0]   <= (a_dmag_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= a_valid_ff;
      end
   end

   // Restoring division, one quotient bit per stage.
   for (genvar k = 1; k <= QB; k++) begin : g_div
      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [RW:0]   rem_sh;
         logic [RW-1:0] rem_in;
         logic          qbit;

         always_comb begin
            rem_sh = {rem_ff[k-1][l], nlow_ff[k-1][l][QB-1]};
            qbit   = (rem_sh >= {1'b0, dmag_ff[k-1]});
            rem_in = qbit ? RW'(rem_sh - {1'b0, dmag_ff[k-1]}) : RW'(rem_sh);
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[k][l]  <= rem_in;
               q_ff[k][l]    <= {q_ff[k-1][l][QB-2:0], qbit};
               nlow_ff[k][l] <= nlow_ff[k-1][l] << 1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            kind_ff[k] <= kind_ff[k-1];
            dmag_ff[k] <= dmag_ff[k-1];
            nz_ff[k]   <= nz_ff[k-1];
            ovf_ff[k]  <= ovf_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            nneg_ff[k] <= nneg_ff[k-1];
            dz_ff[k]   <= dz_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   // ---- Guarded quotients and result formatting ----
   logic [CW-1:0] mag [2];
   logic [CW-1:0] res [2];
   logic [1:0]    sgn;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         if (nz_ff[QB][l]) begin
            mag[l] = '0;
            sgn[l] = 1'b0;
         end else if (dz_ff[QB]) begin
            mag[l] = {1'b0, lim};
            sgn[l] = nneg_ff[QB][l];
         end else if (ovf_ff[QB][l]) begin
            mag[l] = {1'b0, lim};
            sgn[l] = neg_ff[QB][l];
         end else begin
            mag[l] = {1'b0, q_ff[QB][l]};
            sgn[l] = neg_ff[QB][l];
         end
         res[l] = sgn[l] ? CW'(-mag[l]) : mag[l];
      end

      case (kind_ff[QB])
         KIND_TWO: begin
            out_count  = COUNT_TWO;
            out_first  = res[0];
            out_second = res[1];
         end
         KIND_ONE, KIND_LIN: begin
            out_count  = COUNT_ONE;
            out_first  = res[0];
            out_second = '0;
         end
         default: begin
            out_count  = COUNT_NONE;
            out_first  = '0;
            out_second = '0;
         end
      endcase
   end

   assign out_valid = valid_ff[QB];

endmodule
`default_nettype wire

/* hw/rtl/quadratic_roots_safe_divide.sv */
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: the square root has COEF_WIDTH+1 stages and the dividers COEF_WIDTH-1 stages.
// Throughput: one item per cycle; every stage is pipelined and the output register
// stalls the arithmetic pipeline only while a result waits to be taken.
// Reset: synchronous, clears all valid flags, the queue and sets large_value to 2^31-1.
// -----------------------------------------------------------------------------
// quadratic_roots_safe_divide
// Real roots of a*x^2+b*x+c over signed fixed-point coefficients with
// guarded division.
// -----------------------------------------------------------------------------
module quadratic_roots_safe_divide import qrsd_pkg::*; #(
   parameter int COEF_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire                                          clock,
   input  wire                                          reset,
   // Coefficients from bit 0: coef_a, coef_b, coef_c, zero fill.
   input  wire                                          req_tvalid,
   output logic                                         req_tready,
   input  wire  [((3*COEF_WIDTH+7)/8)*8-1:0]            req_tdata,
   // Results from bit 0: root_count, root_first, root_second, zero fill.
   output logic                                         rsp_tvalid,
   input  wire                                          rsp_tready,
   output logic [((2+2*COEF_WIDTH+7)/8)*8-1:0]          rsp_tdata,
   // Large-value register write.
   input  wire                                          csr_valid,
   output logic                                         csr_ready,
   input  wire  [LARGE_W-1:0]                           csr_data
);

   localparam int CW    = COEF_WIDTH;
   localparam int EW    = KIND_W + 3 + 3*CW;
   localparam int RSP_W = ((2+2*CW+7)/8)*8;
   localparam int LMW   = (CW-1 > LARGE_W) ? CW-1 : LARGE_W;
   localparam logic [CW-2:0] MAX_MAG = {(CW-1){1'b1}};

   logic               adv;
   logic               f_valid, q_ready, q_valid, q_pop;
   logic [EW-1:0]      f_entry, q_entry;
   logic               d_valid, s_valid, v_valid;
   logic [2*CW+1:0]    d_rad;
   logic [EW-1:0]      d_tag, s_tag;
   logic [CW:0]        s_root;
   logic [1:0]         v_count;
   logic [CW-1:0]      v_first, v_second;
   logic [LARGE_W-1:0] large_ff;
   logic [LMW-1:0]     lim_wide;
   logic [CW-2:0]      lim;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff;

   // Configuration register; always ready.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         large_ff <= LARGE_RESET;
      end else if (csr_valid) begin
         large_ff <= csr_data;
      end
   end

   // The saturation value never exceeds the largest coefficient magnitude.
   always_comb begin
      lim_wide = (LMW'(large_ff) < LMW'(MAX_MAG)) ? LMW'(large_ff) : LMW'(MAX_MAG);
      lim      = lim_wide[CW-2:0];
   end

   // The whole back pipeline moves whenever the output register can load.
   assign adv   = !rsp_valid_ff || rsp_tready;
   assign q_pop = q_valid && adv;

   qrsd_front #(.COEF_WIDTH(CW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_a      (req_tdata[CW-1:0]),
      .in_b      (req_tdata[2*CW-1:CW]),
      .in_c      (req_tdata[3*CW-1:2*CW]),
      .out_ready (q_ready),
      .out_valid (f_valid),
      .out_entry (f_entry)
   );

   qrsd_queue #(.WIDTH(EW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (q_ready),
      .in_data   (f_entry),
      .out_pop   (q_pop),
      .out_valid (q_valid),
      .out_data  (q_entry)
   );

   qrsd_disc #(.COEF_WIDTH(CW)) u_disc (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (q_valid),
      .in_entry  (q_entry),
      .out_valid (d_valid),
      .out_rad   (d_rad),
      .out_tag   (d_tag)
   );

   qrsd_sqrt #(.COEF_WIDTH(CW), .TAG_W(EW)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (d_valid),
      .in_rad    (d_rad),
      .in_tag    (d_tag),
      .out_valid (s_valid),
      .out_root  (s_root),
      .out_tag   (s_tag)
   );

   qrsd_solve #(.COEF_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_solve (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (s_valid),
      .in_root    (s_root),
      .in_tag     (s_tag),
      .lim        (lim),
      .out_valid  (v_valid),
      .out_count  (v_count),
      .out_first  (v_first),
      .out_second (v_second)
   );

   // Output register.
   always_comb begin
      rsp_valid_in = adv ? v_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && v_valid) begin
         rsp_data_ff <= RSP_W'({v_second, v_first, v_count});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A root count is never above two.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == COUNT_NONE || rsp_tdata[1:0] == COUNT_ONE ||
                      rsp_tdata[1:0] == COUNT_TWO))
      else $error("root count out of range");

   // Absent roots read as zero.
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] != COUNT_TWO) |-> (rsp_tdata[2*CW+1:CW+2] == '0))
      else $error("second root not zero");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] == COUNT_NONE) |-> (rsp_tdata[CW+1:2] == '0))
      else $error("first root not zero");

   // No result is shown straight after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for the quadratic root solver with guarded division.
// Coefficient items are queued by a stimulus process and fed by a clocked
// driver; a clocked monitor compares every result with the roots predicted
// in the bench, under random idling on both sides and several large values.
// -----------------------------------------------------------------------------
module tb;
   import qrsd_pkg::*;

   localparam int CW = 32;
   localparam int FB = 16;
   localparam int REQ_W = ((3*CW+7)/8)*8;
   localparam int RSP_W = ((2+2*CW+7)/8)*8;
   localparam int LATENCY = 2*CW+6;
   localparam logic [CW-1:0] MAX_POS = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] MIN_NEG = {1'b1, {(CW-1){1'b0}}};

   typedef struct packed {
      logic [CW-1:0] c;
      logic [CW-1:0] b;
      logic [CW-1:0] a;
   } coef_t;

   typedef struct packed {
      logic [CW-1:0] second;
      logic [CW-1:0] first;
      logic [1:0]    count;
   } roots_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [LARGE_W-1:0] csr_data = '0;

   coef_t  pending_coefs[$];
   roots_t expected_roots[$];
   logic [LARGE_W-1:0] large_value;
   int  error_count = 0;
   bit  sender_idling_on = 1'b1;
   bit  receiver_idling_on = 1'b1;
   bit  req_taken = 1'b0;
   int  send_gap = 0;
   int  take_gap = 0;
   int  hold_off = 0;

   always #6 clock = ~clock;

   quadratic_roots_safe_divide #(.COEF_WIDTH(CW), .FRAC_BITS(FB)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // Guarded quotient n/d in fixed point, saturated to the large value.
   function automatic logic signed [CW-1:0] safe_quotient(input logic signed [CW+2:0] num,
                                                         input logic signed [CW+2:0] den);
      logic [CW-1:0] lim;
      logic [CW+2:0] mn, md;
      logic [CW+FB+2:0] q;
      logic [CW-1:0] mag;
      bit neg;
      lim = ({1'b0, large_value} < MAX_POS) ? {1'b0, large_value} : MAX_POS;
      if (num == 0) return '0;
      if (den == 0) return (num < 0) ? -lim : lim;
      neg = (num < 0) != (den < 0);
      mn = (num < 0) ? -num : num;
      md = (den < 0) ? -den : den;
      q = ({{FB{1'b0}}, mn} << FB) / {{FB{1'b0}}, md};
      mag = (q > MAX_POS) ? lim : q[CW-1:0];
      return neg ? -mag : mag;
   endfunction

   // Integer square root of the discriminant, rounded down.
   function automatic logic [CW+1:0] floor_sqrt(input logic [2*CW+3:0] v);
      logic [CW+1:0] r;
      logic [CW+1:0] cand;
      r = '0;
      for (int i = CW + 1; i >= 0; i--) begin
         cand = r | ((CW+2)'(1) << i);
         if ({{(CW+2){1'b0}}, cand} * {{(CW+2){1'b0}}, cand} <= v) r = cand;
      end
      return r;
   endfunction

   function automatic roots_t solve_roots(input coef_t k);
      logic signed [CW+2:0] a, b, c, s;
      logic signed [2*CW+5:0] disc;
      roots_t r;
      a = $signed(k.a);
      b = $signed(k.b);
      c = $signed(k.c);
      r = '0;
      if (a == 0) begin
         if (b != 0) begin
            r.count = COUNT_ONE;
            r.first = safe_quotient(-c, b);
         end
      end else begin
         disc = b * b - 4 * a * c;
         if (disc == 0) begin
            r.count = COUNT_ONE;
            r.first = safe_quotient(-b, 2 * a);
         end else if (disc > 0) begin
            s = $signed({1'b0, floor_sqrt(disc[2*CW+3:0])});
            r.count = COUNT_TWO;
            r.first = safe_quotient(-b - s, 2 * a);
            r.second = safe_quotient(-b + s, 2 * a);
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [CW-1:0] got,
                                  input logic [CW-1:0] want);
      $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Input handshake: an item is taken at the rising edge it is accepted.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         expected_roots.push_back(solve_roots(pending_coefs.pop_front()));
         req_taken = 1'b1;
      end
   end

   // Driver: offers queued items, changing inputs on the falling edge.
   // An offered item stays on the bus until it has been accepted.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && !req_taken) begin
            req_tvalid <= 1'b1;
         end else if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (sender_idling_on && $urandom_range(0, 29) == 0) begin
            send_gap = $urandom_range(1, 18);
            req_tvalid <= 1'b0;
         end else if (pending_coefs.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= REQ_W'(pending_coefs[0]);
         end else begin
            req_tvalid <= 1'b0;
         end
         req_taken = 1'b0;
      end
   end

   // Receiver readiness, including the long hold-off.
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_off > 0) begin
            hold_off--;
            rsp_tready <= 1'b0;
         end else if (take_gap > 0) begin
            take_gap--;
            rsp_tready <= 1'b0;
         end else if (receiver_idling_on && $urandom_range(0, 29) == 0) begin
            take_gap = $urandom_range(1, 18);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Monitor: checks each accepted result against the oldest prediction.
   always @(posedge clock) begin
      roots_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(roots_t)-1:0];
         if (expected_roots.size() == 0) begin
            report_mismatch("unexpected result", CW'(got.count), '0);
         end else begin
            want = expected_roots.pop_front();
            if (got.count != want.count) report_mismatch("root_count", CW'(got.count),
                                                         CW'(want.count));
            if (got.first != want.first) report_mismatch("root_first", got.first, want.first);
            if (got.second != want.second) report_mismatch("root_second", got.second,
                                                            want.second);
         end
      end
   end

   task automatic write_large_value(input logic [LARGE_W-1:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      large_value = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_coefs.size() > 0 || req_tvalid || expected_roots.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   function automatic logic [CW-1:0] random_coef();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return MAX_POS;
         2: return MIN_NEG;
         3: return CW'($signed($urandom_range(0, 16)) - 8) << FB;
         4: return CW'($signed($urandom_range(0, 200)) - 100);
         default: return $urandom();
      endcase
   endfunction

   task automatic queue_random(input int n);
      coef_t k;
      logic signed [CW-1:0] r1, r2, sc;
      for (int i = 0; i < n; i++) begin
         k.a = random_coef();
         k.b = random_coef();
         k.c = random_coef();
         // Often build a, b, c from chosen roots so the two-root path is busy.
         if ($urandom_range(0, 2) == 0) begin
            r1 = $signed(CW'($urandom_range(0, 64))) - 32;
            r2 = $signed(CW'($urandom_range(0, 64))) - 32;
            sc = $signed(CW'($urandom_range(1, 255)));
            if ($urandom_range(0, 1)) sc = -sc;
            k.a = sc << FB;
            k.b = -(sc * (r1 + r2)) << FB;
            k.c = (sc * r1 * r2) << FB;
         end
         pending_coefs.push_back(k);
      end
   endtask

   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      coef_t k;
      large_value = LARGE_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: linear, degenerate, double, complex and extreme cases.
      k = '{a: '0, b: '0, c: 32'h0001_0000}; pending_coefs.push_back(k);
      k = '{a: '0, b: 32'h0002_0000, c: 32'hFFFC_0000}; pending_coefs.push_back(k);
      k = '{a: '0, b: 32'h0000_0001, c: MAX_POS}; pending_coefs.push_back(k);
      k = '{a: '0, b: 32'h0001_0000, c: '0}; pending_coefs.push_back(k);
      k = '{a: 32'h0001_0000, b: 32'hFFFE_0000, c: 32'h0001_0000};
      pending_coefs.push_back(k);
      k = '{a: 32'h0001_0000, b: '0, c: 32'h0001_0000}; pending_coefs.push_back(k);
      k = '{a: 32'h0001_0000, b: '0, c: 32'hFFFF_0000}; pending_coefs.push_back(k);
      k = '{a: 32'hFFFF_0000, b: 32'h0003_0000, c: 32'h0004_0000};
      pending_coefs.push_back(k);
      k = '{a: MIN_NEG, b: MIN_NEG, c: MIN_NEG}; pending_coefs.push_back(k);
      k = '{a: MAX_POS, b: MAX_POS, c: MAX_POS}; pending_coefs.push_back(k);
      k = '{a: MIN_NEG, b: MAX_POS, c: MAX_POS}; pending_coefs.push_back(k);
      k = '{a: 32'h0000_0001, b: MIN_NEG, c: '0}; pending_coefs.push_back(k);
      k = '{a: 32'h0000_0001, b: '0, c: MIN_NEG}; pending_coefs.push_back(k);
      k = '{a: 32'hFFFF_FFFF, b: 32'hFFFF_FFFF, c: 32'hFFFF_FFFF};
      pending_coefs.push_back(k);
      wait_drained();

      // The sender pauses here until every result has come back.
      write_large_value('0);
      queue_random(60);
      wait_drained();

      // Long receiver hold-off so the pipeline fills and stalls its input.
      write_large_value(31'd12345);
      hold_off = 300;
      queue_random(140);
      wait_drained();

      write_large_value(31'h0100_0000);
      queue_random(150);
      wait_drained();

      // Last part at full rate with no idling.
      write_large_value(LARGE_RESET);
      sender_idling_on = 1'b0;
      receiver_idling_on = 1'b0;
      queue_random(150);
      wait_drained();

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
